// File: rtl/stgd_pkg.sv
// Package for the segment translate unit: payload structs, request and
// status codes, and the width constants. No dependencies.
package stgd_pkg;

    localparam int AW = 48;
    localparam int SW = 49;
    localparam int NUM_SEGS = 8;

    localparam logic [2:0] REQ_TRANSLATE = 3'd0;
    localparam logic [2:0] REQ_PROBE     = 3'd1;
    localparam logic [2:0] REQ_MAP       = 3'd2;
    localparam logic [2:0] REQ_UNMAP     = 3'd3;
    localparam logic [2:0] REQ_ACCESS    = 3'd4;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_UNMAPPED = 4'd1;
    localparam logic [3:0] ST_CROSS    = 4'd2;
    localparam logic [3:0] ST_PROT     = 4'd3;
    localparam logic [3:0] ST_NOROOM   = 4'd4;
    localparam logic [3:0] ST_OVERLIM  = 4'd5;
    localparam logic [3:0] ST_OVERLAP  = 4'd6;
    localparam logic [3:0] ST_NOSEG    = 4'd7;
    localparam logic [3:0] ST_FULL     = 4'd8;

    localparam logic CFG_MIN_BASE = 1'b0;
    localparam logic CFG_ALIGN    = 1'b1;

    typedef struct packed {
        logic [2:0]    req_type;
        logic [AW-1:0] addr;
        logic [3:0]    access_width;
        logic [3:0]    req_access;
        logic [SW-1:0] seg_size;
        logic [SW-1:0] grow_limit;
        logic          auto_grow;
    } req_t;

    typedef struct packed {
        logic [3:0]    status;
        logic [2:0]    seg_index;
        logic [AW-1:0] offset;
        logic          grew;
        logic [AW-1:0] seg_new_base;
    } rsp_t;

endpackage

// File: rtl/segment_translate_grow_down_unit.sv
// Top level of the segment translate unit: segment table, sequencer and
// one shared 64-bit subtract/compare unit. Depends on stgd_pkg.
//
//  Channel | Direction | Handshake        | Payload
//  s_      | in        | s_valid/s_ready  | stgd_pkg::req_t
//  m_      | out       | m_valid/m_ready  | stgd_pkg::rsp_t
//  cfg     | in        | cfg_we           | cfg_index, cfg_data
//
// A beat runs from acceptance to result through the table scan, one step per
// free entry and two per live one, then three to five more steps.
// A growing translate adds up to 70 doubling steps of one or two passes
// each and up to eight more steps.
// Reset (aresetn low, synchronous) clears valid bits and the sequencer, and sets
// the config registers to defaults. A result waits in the output register; the
// next beat is taken only after the result is taken.
module segment_translate_grow_down_unit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  stgd_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output stgd_pkg::rsp_t m_data,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [47:0]    cfg_data
);
    import stgd_pkg::*;

    localparam int IW = (NUM_SEGS > 1) ? $clog2(NUM_SEGS) : 1;
    localparam int CW = $clog2(NUM_SEGS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN, S_CMP, S_DEC, S_GLOOP, S_GALIGN, S_GBELOW, S_GMIN,
        S_GLIM, S_GFIT, S_GCHK, S_CHK, S_MAP1, S_MAP2, S_OUT
    } state_t;

    state_t state_reg;
    logic [NUM_SEGS-1:0] vld_reg;
    logic [AW-1:0] base_mem [NUM_SEGS];
    logic [SW-1:0] len_mem  [NUM_SEGS];
    logic [SW-1:0] lim_mem  [NUM_SEGS];
    logic [3:0]    acc_mem  [NUM_SEGS];
    logic          gd_mem   [NUM_SEGS];

    logic [AW-1:0] min_base_reg;
    logic [4:0]    align_reg;
    req_t          req_reg;
    rsp_t          rsp_reg;
    logic          m_valid_reg;
    logic [CW-1:0] cnt_reg;
    logic [6:0]    k_reg;
    logic [1:0]    sub_reg;  // scan sub-step
    logic [AW-1:0] a_reg;
    logic [3:0]    w_reg;
    logic          bel_ok_reg, abv_ok_reg, exa_ok_reg, fre_ok_reg;
    logic [IW-1:0] bel_reg, abv_reg, exa_reg, fre_reg, s_reg;
    logic [63:0]   last_reg, size_reg, nb_reg, blast_reg;
    logic [SW-1:0] maxs_reg;

    // Shared subtractor: diff = x - y, with borrow as "x < y".
    logic [63:0] x_op, y_op;
    logic [64:0] diff;
    logic        lt;
    assign diff = {1'b0, x_op} - {1'b0, y_op};
    assign lt   = diff[64];

    logic [IW-1:0] ci;
    assign ci = cnt_reg[IW-1:0];
    logic [63:0] alm;
    assign alm = (64'd1 << align_reg) - 64'd1;

    // Operand selection per step.
    always_comb begin
        x_op = '0;
        y_op = '0;
        unique case (state_reg)
            S_SCAN: begin
                unique case (sub_reg)
                    2'd0: begin x_op = {16'd0, a_reg}; y_op = {16'd0, base_mem[ci]}; end
                    2'd1: begin x_op = {16'd0, base_mem[ci]}; y_op = {16'd0, base_mem[bel_reg]}; end
                    default: begin x_op = {16'd0, base_mem[ci]}; y_op = {16'd0, base_mem[abv_reg]}; end
                endcase
            end
            S_CMP:  begin x_op = last_reg; y_op = {16'd0, a_reg}; end
            S_GLOOP: begin
                if (sub_reg == 2'd0) begin x_op = last_reg; y_op = size_reg; end
                else begin x_op = last_reg - size_reg; y_op = size_reg - 64'd1; end
            end
            S_GBELOW: begin x_op = nb_reg; y_op = blast_reg + 64'd1; end
            S_GMIN: begin x_op = nb_reg; y_op = {16'd0, min_base_reg}; end
            S_GLIM: begin x_op = last_reg; y_op = nb_reg; end
            S_GFIT: begin x_op = last_reg; y_op = {15'd0, maxs_reg} - 64'd1; end
            S_CHK:  begin x_op = last_reg - {16'd0, a_reg}; y_op = {60'd0, w_reg} - 64'd1; end
            S_MAP1: begin x_op = {16'd0, {AW{1'b1}}} - {16'd0, a_reg};
                          y_op = {15'd0, req_reg.seg_size} - 64'd1; end
            S_MAP2: begin x_op = {16'd0, a_reg} + {15'd0, req_reg.seg_size} - 64'd1;
                          y_op = {16'd0, base_mem[abv_reg]}; end
            default: ;
        endcase
    end

    logic [3:0] wz;
    assign wz = (s_data.access_width == 4'd0) ? 4'd1 : s_data.access_width;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            vld_reg      <= '0;
            m_valid_reg  <= 1'b0;
            min_base_reg <= 48'h1000;
            align_reg    <= 5'd13;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_MIN_BASE) min_base_reg <= cfg_data;
                else align_reg <= cfg_data[4:0];
            end
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (s_valid && !m_valid_reg) begin
                    req_reg <= s_data;
                    w_reg   <= wz;
                    a_reg   <= (s_data.req_type <= REQ_PROBE && (wz == 4'd1 || wz == 4'd2 ||
                                wz == 4'd4 || wz == 4'd8)) ?
                               (s_data.addr & ~(48'(wz) - 48'd1)) : s_data.addr;
                    bel_ok_reg <= 1'b0; abv_ok_reg <= 1'b0;
                    exa_ok_reg <= 1'b0; fre_ok_reg <= 1'b0;
                    cnt_reg <= '0; sub_reg <= 2'd0;
                    rsp_reg <= '0;
                    state_reg <= S_SCAN;
                end
                S_SCAN: begin
                    // Sub-steps per live entry through the shared unit: the address, then below or above.
                    if (!vld_reg[ci]) begin
                        if (!fre_ok_reg) begin fre_ok_reg <= 1'b1; fre_reg <= ci; end
                        sub_reg <= 2'd0;
                        cnt_reg <= cnt_reg + 1'b1;
                    end else if (sub_reg == 2'd0) begin
                        if (diff[63:0] == 64'd0) begin exa_ok_reg <= 1'b1; exa_reg <= ci; end
                        sub_reg <= lt ? 2'd2 : 2'd1;
                    end else if (sub_reg == 2'd1) begin
                        if (!bel_ok_reg || !lt) begin bel_ok_reg <= 1'b1; bel_reg <= ci; end
                        sub_reg <= 2'd0; cnt_reg <= cnt_reg + 1'b1;
                    end else begin
                        if (!abv_ok_reg || lt) begin abv_ok_reg <= 1'b1; abv_reg <= ci; end
                        sub_reg <= 2'd0; cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (cnt_reg == CW'(NUM_SEGS - 1) && (!vld_reg[ci] || sub_reg != 2'd0))
                        state_reg <= S_CMP;
                    last_reg <= {16'd0, base_mem[bel_reg]} + {15'd0, len_mem[bel_reg]} - 64'd1;
                end
                S_CMP: begin
                    // Last byte of the entry below, for the hit test and growth.
                    last_reg <= {16'd0, base_mem[bel_reg]} + {15'd0, len_mem[bel_reg]} - 64'd1;
                    blast_reg <= {16'd0, base_mem[bel_reg]} + {15'd0, len_mem[bel_reg]} - 64'd1;
                    state_reg <= S_DEC;
                end
                S_DEC: begin
                    unique case (req_reg.req_type) inside
                        REQ_TRANSLATE, REQ_PROBE: begin
                            if (bel_ok_reg && !(last_reg < {16'd0, a_reg})) begin
                                s_reg <= bel_reg;
                                rsp_reg.seg_index <= 3'(bel_reg);
                                state_reg <= S_CHK;
                            end else if (req_reg.req_type == REQ_TRANSLATE && abv_ok_reg &&
                                         a_reg != '0 && gd_mem[abv_reg] &&
                                         !acc_mem[abv_reg][3]) begin
                                s_reg <= abv_reg;
                                rsp_reg.seg_index <= 3'(abv_reg);
                                last_reg <= {16'd0, base_mem[abv_reg]} +
                                            {15'd0, len_mem[abv_reg]} - 64'd1;
                                size_reg <= {15'd0, len_mem[abv_reg]};
                                nb_reg   <= {16'd0, base_mem[abv_reg]};
                                maxs_reg <= lim_mem[abv_reg];
                                k_reg <= '0; sub_reg <= 2'd0;
                                state_reg <= S_GLOOP;
                            end else begin
                                rsp_reg.status <= ST_UNMAPPED;
                                state_reg <= S_OUT;
                            end
                        end
                        REQ_MAP: state_reg <= S_MAP1;
                        REQ_UNMAP, REQ_ACCESS: begin
                            if (!exa_ok_reg) rsp_reg.status <= ST_NOSEG;
                            else begin
                                rsp_reg.seg_index <= 3'(exa_reg);
                                rsp_reg.seg_new_base <= base_mem[exa_reg];
                                if (req_reg.req_type == REQ_UNMAP) vld_reg[exa_reg] <= 1'b0;
                                else acc_mem[exa_reg] <= req_reg.req_access;
                            end
                            state_reg <= S_OUT;
                        end
                        default: begin
                            rsp_reg.status <= ST_NOSEG;
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_GLOOP: begin
                    // One doubling step through the subtractor: last against size, then room to double.
                    if (!(nb_reg > {16'd0, a_reg}) || k_reg == 7'd70) state_reg <= S_GALIGN;
                    else if (sub_reg == 2'd0) begin
                        if (lt) begin nb_reg <= {16'd0, a_reg}; k_reg <= k_reg + 1'b1; end
                        else sub_reg <= 2'd1;
                    end else begin
                        if (lt) nb_reg <= {16'd0, a_reg};
                        else begin
                            size_reg <= size_reg << 1;
                            nb_reg <= last_reg - ((size_reg << 1) - 64'd1);
                        end
                        k_reg <= k_reg + 1'b1;
                        sub_reg <= 2'd0;
                    end
                end
                S_GALIGN: begin nb_reg <= nb_reg & ~alm; state_reg <= S_GBELOW; end
                S_GBELOW: begin
                    if (bel_ok_reg && lt) nb_reg <= blast_reg + 64'd1;
                    state_reg <= S_GMIN;
                end
                S_GMIN: begin
                    if (lt) nb_reg <= {16'd0, min_base_reg};
                    state_reg <= S_GLIM;
                end
                S_GLIM: begin
                    if (lt) begin
                        rsp_reg.status <= ST_NOROOM;
                        rsp_reg.seg_new_base <= base_mem[s_reg];
                        state_reg <= S_OUT;
                    end else begin
                        size_reg <= diff[63:0];  // size minus one
                        state_reg <= (diff[63:0] >= {15'd0, maxs_reg}) ? S_GFIT : S_GCHK;
                    end
                end
                S_GFIT: begin
                    if (!lt && !(diff[63:0] > {16'd0, a_reg})) begin
                        nb_reg <= diff[63:0];
                        size_reg <= {15'd0, maxs_reg} - 64'd1;
                    end else begin
                        nb_reg <= {16'd0, a_reg} & ~alm;
                        size_reg <= last_reg - ({16'd0, a_reg} & ~alm);
                    end
                    state_reg <= S_GCHK;
                end
                S_GCHK: begin
                    if (nb_reg > {16'd0, a_reg}) begin
                        rsp_reg.status <= ST_NOROOM;
                        rsp_reg.seg_new_base <= base_mem[s_reg];
                        state_reg <= S_OUT;
                    end else if (size_reg >= {15'd0, maxs_reg}) begin
                        rsp_reg.status <= ST_OVERLIM;
                        rsp_reg.seg_new_base <= base_mem[s_reg];
                        state_reg <= S_OUT;
                    end else begin
                        base_mem[s_reg] <= nb_reg[AW-1:0];
                        len_mem[s_reg]  <= SW'(size_reg + 64'd1);
                        rsp_reg.grew <= 1'b1;
                        last_reg <= last_reg;
                        state_reg <= S_CHK;
                    end
                end
                S_CHK: begin
                    rsp_reg.offset <= a_reg - base_mem[s_reg];
                    rsp_reg.seg_new_base <= base_mem[s_reg];
                    if (lt) rsp_reg.status <= ST_CROSS;
                    else if ((req_reg.req_access & acc_mem[s_reg]) !=
                             (req_reg.req_access & 4'd7)) rsp_reg.status <= ST_PROT;
                    state_reg <= S_OUT;
                end
                S_MAP1: begin
                    if (req_reg.seg_size == '0 || lt ||
                        (bel_ok_reg && !(blast_reg < {16'd0, a_reg}))) begin
                        rsp_reg.status <= ST_OVERLAP;
                        state_reg <= S_OUT;
                    end else state_reg <= S_MAP2;
                end
                S_MAP2: begin
                    if (abv_ok_reg && !lt) rsp_reg.status <= ST_OVERLAP;
                    else if (!fre_ok_reg) rsp_reg.status <= ST_FULL;
                    else begin
                        rsp_reg.seg_index    <= 3'(fre_reg);
                        rsp_reg.seg_new_base <= a_reg;
                        vld_reg[fre_reg]  <= 1'b1;
                        base_mem[fre_reg] <= a_reg;
                        len_mem[fre_reg]  <= req_reg.seg_size;
                        lim_mem[fre_reg]  <= (req_reg.grow_limit < req_reg.seg_size) ?
                                             req_reg.seg_size : req_reg.grow_limit;
                        acc_mem[fre_reg]  <= req_reg.req_access;
                        gd_mem[fre_reg]   <= req_reg.auto_grow;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    m_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;

    // A beat is never taken while a result waits.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !m_valid) else $error("overrun");
    // A result appears only from the output step.
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_OUT)) else $error("stray result");
    // Grew is only reported with ok, cross or protection status.
    a_grew: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.grew |-> m_data.status <= ST_PROT) else $error("grew status");
endmodule

// File: bench/testbench.sv
// Self-checking testbench for segment_translate_grow_down_unit: directed table
// plus random requests, each result checked against a typed result or a
// built-in segment table model. Depends on stgd_pkg and the unit's RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import stgd_pkg::*;

    localparam int SEGS = NUM_SEGS;
    localparam logic [63:0] AMASK = 64'hFFFF_FFFF_FFFF;
    localparam int RANDOM_ITEMS = 520;

    typedef struct {
        req_t req;
        bit   known;
        rsp_t rsp;
    } row_t;

    logic  aclk = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    req_t  s_data = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    rsp_t  m_data;
    logic  cfg_we = 1'b0;
    logic  cfg_index = CFG_MIN_BASE;
    logic [47:0] cfg_data = '0;

    // Shadow copy of the segment table and registers.
    logic [63:0] tbl_base[SEGS];
    logic [63:0] tbl_len[SEGS];
    logic [63:0] tbl_lim[SEGS];
    logic [3:0]  tbl_acc[SEGS];
    bit          tbl_valid[SEGS];
    bit          tbl_down[SEGS];
    logic [63:0] floor_base;
    logic [4:0]  align_log2;

    rsp_t pending_rsp[$];
    row_t rows[$];
    int   errors = 0;

    segment_translate_grow_down_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [63:0] seg_end(int i);
        return tbl_base[i] + tbl_len[i] - 64'd1;
    endfunction

    // Find the segment at or below an address and the nearest one above.
    function automatic void find_near(logic [63:0] a, output int hit, output int lo,
                                      output int hi);
        lo = -1;
        hi = -1;
        for (int i = 0; i < SEGS; i++) begin
            if (!tbl_valid[i]) continue;
            if (tbl_base[i] <= a) begin
                if (lo < 0 || tbl_base[i] > tbl_base[lo]) lo = i;
            end else if (hi < 0 || tbl_base[i] < tbl_base[hi]) begin
                hi = i;
            end
        end
        hit = (lo >= 0 && a <= seg_end(lo)) ? lo : -1;
    endfunction

    // Downward growth of segment s toward va; returns a status code.
    function automatic logic [3:0] grow_segment(int s, int lo, logic [63:0] va);
        logic [63:0] last, size, nb, maxs, alm, sm1;
        bit fits;
        last = seg_end(s);
        size = tbl_len[s];
        nb = tbl_base[s];
        maxs = tbl_lim[s];
        alm = (64'd1 << align_log2) - 64'd1;
        for (int k = 0; k < 70 && nb > va; k++) begin
            if (last < size || size - 64'd1 > last - size) begin
                nb = va;
            end else begin
                size = size << 1;
                nb = last - (size - 64'd1);
            end
        end
        nb = nb & ~alm;
        if (lo >= 0 && nb < seg_end(lo) + 64'd1) nb = seg_end(lo) + 64'd1;
        if (nb < floor_base) nb = floor_base;
        if (nb > last) return ST_NOROOM;
        sm1 = last - nb;
        if (sm1 >= maxs) begin
            fits = (maxs - 64'd1 <= last) && (last - (maxs - 64'd1) <= va);
            if (fits) begin
                nb = last - (maxs - 64'd1);
                sm1 = maxs - 64'd1;
            end else begin
                nb = va & ~alm;
                sm1 = last - nb;
            end
        end
        if (nb > va) return ST_NOROOM;
        if (sm1 >= maxs) return ST_OVERLIM;
        tbl_base[s] = nb;
        tbl_len[s] = sm1 + 64'd1;
        return ST_OK;
    endfunction

    // Expected response of one request; updates the shadow table.
    function automatic rsp_t translate_request(req_t r);
        rsp_t o;
        logic [63:0] a, w, sz, mx;
        int hit, lo, hi, s, idx, i;
        o = '0;
        idx = -1;
        a = {16'd0, r.addr};
        w = (r.access_width == 0) ? 64'd1 : {60'd0, r.access_width};
        sz = {15'd0, r.seg_size};
        mx = {15'd0, r.grow_limit};
        if (r.req_type == REQ_TRANSLATE || r.req_type == REQ_PROBE) begin
            s = -1;
            if (w == 1 || w == 2 || w == 4 || w == 8) a = a & ~(w - 64'd1);
            find_near(a, hit, lo, hi);
            if (hit >= 0) begin
                s = hit;
            end else if (r.req_type == REQ_TRANSLATE && hi >= 0 && a != 0 &&
                         tbl_down[hi] && !tbl_acc[hi][3]) begin
                o.status = grow_segment(hi, lo, a);
                idx = hi;
                if (o.status == ST_OK) begin
                    s = hi;
                    o.grew = 1'b1;
                end
            end else begin
                o.status = ST_UNMAPPED;
            end
            if (s >= 0) begin
                idx = s;
                o.offset = 48'(a - tbl_base[s]);
                if (w - 64'd1 > seg_end(s) - a) o.status = ST_CROSS;
                else if ((r.req_access & tbl_acc[s]) != (r.req_access & 4'd7))
                    o.status = ST_PROT;
            end
        end else if (r.req_type == REQ_MAP) begin
            find_near(a, hit, lo, hi);
            if (sz == 0 || sz - 64'd1 > AMASK - a || hit >= 0 ||
                (hi >= 0 && tbl_base[hi] <= a + (sz - 64'd1))) begin
                o.status = ST_OVERLAP;
            end else begin
                for (i = 0; i < SEGS && tbl_valid[i]; i++) begin
                end
                if (i >= SEGS) begin
                    o.status = ST_FULL;
                end else begin
                    idx = i;
                    tbl_valid[i] = 1'b1;
                    tbl_base[i] = a;
                    tbl_len[i] = sz;
                    tbl_lim[i] = (mx < sz) ? sz : mx;
                    tbl_acc[i] = r.req_access;
                    tbl_down[i] = r.auto_grow;
                end
            end
        end else if (r.req_type == REQ_UNMAP || r.req_type == REQ_ACCESS) begin
            for (i = 0; i < SEGS; i++)
                if (idx < 0 && tbl_valid[i] && tbl_base[i] == a) idx = i;
            if (idx < 0) o.status = ST_NOSEG;
            else if (r.req_type == REQ_UNMAP) tbl_valid[idx] = 1'b0;
            else tbl_acc[idx] = r.req_access;
        end else begin
            o.status = ST_NOSEG;
        end
        if (idx >= 0) begin
            o.seg_index = 3'(idx);
            o.seg_new_base = 48'(tbl_base[idx]);
        end
        return o;
    endfunction

    function automatic req_t mk(logic [2:0] t, logic [47:0] a, logic [3:0] w,
                                logic [3:0] acc, logic [48:0] sz, logic [48:0] mx,
                                logic ag);
        req_t r;
        r.req_type = t;
        r.addr = a;
        r.access_width = w;
        r.req_access = acc;
        r.seg_size = sz;
        r.grow_limit = mx;
        r.auto_grow = ag;
        return r;
    endfunction

    function automatic rsp_t res(logic [3:0] st, logic [2:0] idx, logic [47:0] off,
                                 logic g, logic [47:0] b);
        rsp_t o;
        o.status = st;
        o.seg_index = idx;
        o.offset = off;
        o.grew = g;
        o.seg_new_base = b;
        return o;
    endfunction

    function automatic void add(req_t r, bit known = 0, rsp_t e = '0);
        row_t x;
        x.req = r;
        x.known = known;
        x.rsp = e;
        rows.push_back(x);
    endfunction

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    // Base of a random live segment, or a random address in the busy window.
    function automatic logic [63:0] some_base();
        int i;
        i = $urandom_range(SEGS - 1);
        if (tbl_valid[i] && $urandom_range(9) < 8) return tbl_base[i];
        return {32'd0, $urandom_range(32'h3F_FFFF, 0)};
    endfunction

    // Random request, mostly aimed at live segments and the gaps below them.
    function automatic req_t random_request();
        req_t r;
        int pick;
        logic [63:0] b;
        logic [159:0] raw;
        r = mk(REQ_TRANSLATE, '0, 4'($urandom_range(15)), 4'($urandom_range(15)),
               49'($urandom_range(32'h4000, 1)), 49'($urandom_range(32'h40000, 1)),
               1'($urandom_range(1)));
        if ($urandom_range(3) != 0) r.req_access[3] = 1'b0;
        if ($urandom_range(2) != 0) r.access_width = 4'(1 << $urandom_range(3));
        pick = $urandom_range(99);
        b = some_base();
        if (pick < 8) begin
            // Noise across every bit of every field.
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
            r = req_t'(raw[$bits(req_t)-1:0]);
            if ($urandom_range(1)) r.req_type = 3'($urandom_range(4));
        end else if (pick < 50) begin
            r.req_type = ($urandom_range(5) == 0) ? REQ_PROBE : REQ_TRANSLATE;
            case ($urandom_range(2))
                0: r.addr = 48'(b + $urandom_range(32'h3000));
                1: r.addr = 48'(b - $urandom_range(32'h20000, 1));
                default: r.addr = 48'($urandom_range(32'h3F_FFFF));
            endcase
        end else if (pick < 72) begin
            r.req_type = REQ_MAP;
            r.addr = 48'($urandom_range(32'h3F_FFFF) & ~32'hFF);
            if ($urandom_range(9) == 0) r.seg_size = 49'(rand48());
            if ($urandom_range(5) == 0) r.grow_limit = 49'({$urandom, $urandom});
        end else if (pick < 85) begin
            r.req_type = REQ_UNMAP;
            r.addr = 48'(b);
        end else if (pick < 97) begin
            r.req_type = REQ_ACCESS;
            r.addr = 48'(b);
        end else begin
            r.req_type = 3'($urandom_range(7, 5));
            r.addr = rand48();
        end
        return r;
    endfunction

    // Drives one beat from a falling edge; valid stays up when no gap follows.
    task automatic send_beat(req_t r, bit known, rsp_t e);
        rsp_t p;
        int gap;
        gap = ($urandom_range(9) == 0) ? $urandom_range(40, 6) : $urandom_range(2);
        if ($urandom_range(3) == 0) gap = 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data <= r;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        p = translate_request(r);
        pending_rsp.push_back(known ? e : p);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [47:0] v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_MIN_BASE) floor_base = {16'd0, v};
        else align_log2 = v[4:0];
    endtask

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch in %s: got %h expected %h at %t", field, got, want, $realtime);
    endtask

    // Result side: random stalls, with quiet stretches.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(7) == 0)
                    stall = ($urandom_range(9) == 0) ? $urandom_range(40, 5) : $urandom_range(3, 1);
            end
        end
    end

    // Each result beat is matched with the oldest expected response.
    always @(posedge aclk) begin
        rsp_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                report("unexpected beat", 64'(m_data.status), 64'd0);
            end else begin
                w = pending_rsp.pop_front();
                if (m_data.status != w.status)
                    report("status", 64'(m_data.status), 64'(w.status));
                if (m_data.seg_index != w.seg_index)
                    report("seg_index", 64'(m_data.seg_index), 64'(w.seg_index));
                if (m_data.offset != w.offset)
                    report("offset", 64'(m_data.offset), 64'(w.offset));
                if (m_data.grew != w.grew) report("grew", 64'(m_data.grew), 64'(w.grew));
                if (m_data.seg_new_base != w.seg_new_base)
                    report("seg_new_base", 64'(m_data.seg_new_base), 64'(w.seg_new_base));
            end
        end
    end

    initial begin
        logic [47:0] top;
        top = 48'hFFFF_FFFF_F000;
        floor_base = 64'h1000;
        align_log2 = 5'd13;
        for (int i = 0; i < SEGS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_base[i] = '0;
            tbl_len[i] = '0;
            tbl_lim[i] = '0;
            tbl_acc[i] = '0;
            tbl_down[i] = 1'b0;
        end

        // Directed table; typed results only where they are obvious.
        add(mk(REQ_TRANSLATE, 48'h2000, 4, 1, 1, 1, 0), 1, res(ST_UNMAPPED, 0, 0, 0, 0));
        add(mk(REQ_UNMAP, 48'h10000, 1, 0, 1, 1, 0), 1, res(ST_NOSEG, 0, 0, 0, 0));
        add(mk(3'd5, 48'h10000, 1, 0, 1, 1, 0), 1, res(ST_NOSEG, 0, 0, 0, 0));
        add(mk(3'd7, '1, 4'hF, 4'hF, '1, '1, 1), 1, res(ST_NOSEG, 0, 0, 0, 0));
        add(mk(REQ_MAP, 48'h10000, 1, 3, 0, 1, 0), 1, res(ST_OVERLAP, 0, 0, 0, 0));
        add(mk(REQ_MAP, top, 1, 3, 49'h2000, 1, 0), 1, res(ST_OVERLAP, 0, 0, 0, 0));
        add(mk(REQ_MAP, 48'h10000, 1, 3, 49'h1000, 1, 0), 1,
            res(ST_OK, 0, 0, 0, 48'h10000));
        add(mk(REQ_TRANSLATE, 48'h10004, 4, 1, 1, 1, 0), 1,
            res(ST_OK, 0, 4, 0, 48'h10000));
        add(mk(REQ_TRANSLATE, 48'h10FF8, 9, 1, 1, 1, 0), 1,
            res(ST_CROSS, 0, 48'hFF8, 0, 48'h10000));
        add(mk(REQ_TRANSLATE, 48'h10000, 1, 4, 1, 1, 0), 1,
            res(ST_PROT, 0, 0, 0, 48'h10000));
        add(mk(REQ_PROBE, 48'h10000, 0, 9, 1, 1, 0), 1, res(ST_OK, 0, 0, 0, 48'h10000));
        add(mk(REQ_MAP, 48'hF000, 1, 3, 49'h2000, 1, 0), 1, res(ST_OVERLAP, 0, 0, 0, 0));
        add(mk(REQ_MAP, 48'h40000, 1, 7, 49'h2000, 49'h100000, 1), 1,
            res(ST_OK, 1, 0, 0, 48'h40000));
        add(mk(REQ_PROBE, 48'h3F000, 1, 1, 1, 1, 0));
        add(mk(REQ_TRANSLATE, 48'h3F000, 1, 1, 1, 1, 0));
        add(mk(REQ_TRANSLATE, 48'h20000, 2, 2, 1, 1, 0));
        add(mk(REQ_TRANSLATE, 48'h11000, 8, 1, 1, 1, 0));
        add(mk(REQ_ACCESS, 48'h40000, 1, 4'hF, 1, 1, 0));
        add(mk(REQ_MAP, top, 1, 7, 49'h1000, 49'h1_0000_0000_0000, 0), 1,
            res(ST_OK, 2, 0, 0, top));
        add(mk(REQ_TRANSLATE, 48'hFFFF_FFFF_FFFF, 1, 0, 1, 1, 0), 1,
            res(ST_OK, 2, 48'hFFF, 0, top));
        add(mk(REQ_MAP, 0, 1, 7, 49'h1_0000_0000_0000, 1, 0), 1,
            res(ST_OVERLAP, 0, 0, 0, 0));
        add(mk(REQ_UNMAP, top, 1, 0, 1, 1, 0), 1, res(ST_OK, 2, 0, 0, top));
        for (int i = 0; i < 6; i++)
            add(mk(REQ_MAP, 48'(48'h800000 + i * 48'h10000), 1, 3, 49'h100, 49'h100, 0));
        add(mk(REQ_MAP, 48'h900000, 1, 3, 49'h100, 1, 0), 1, res(ST_FULL, 0, 0, 0, 0));
        for (int i = 0; i < 3; i++)
            add(mk(REQ_UNMAP, 48'(48'h800000 + i * 48'h10000), 1, 0, 1, 1, 0));

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) send_beat(rows[i].req, rows[i].known, rows[i].rsp);

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 5; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    write_reg(CFG_MIN_BASE, 48'h1000);
                    write_reg(CFG_ALIGN, 48'd13);
                end
                1: begin
                    write_reg(CFG_MIN_BASE, 48'h0);
                    write_reg(CFG_ALIGN, 48'd0);
                end
                2: begin
                    write_reg(CFG_MIN_BASE, 48'hFFFF_FFFF_FFFF);
                    write_reg(CFG_ALIGN, 48'd30);
                end
                3: begin
                    write_reg(CFG_MIN_BASE, 48'h8_0000);
                    write_reg(CFG_ALIGN, 48'd31);
                end
                default: begin
                    write_reg(CFG_MIN_BASE, rand48() & 48'hF_FFFF);
                    write_reg(CFG_ALIGN, 48'($urandom_range(16)));
                end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 5; n++)
                send_beat(random_request(), 0, '0);
        end

        wait_idle();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// File: filelist.f
rtl/stgd_pkg.sv
rtl/segment_translate_grow_down_unit.sv
bench/testbench.sv
